@@ rtl/segment_distance_phase_field_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the segment distance phase-field block
// Shared forms for the concurrent checks on the block's ports.
// ----------------------------------------------------------------------------
`ifndef SEGMENT_DISTANCE_PHASE_FIELD_ASSERT_SVH
`define SEGMENT_DISTANCE_PHASE_FIELD_ASSERT_SVH

// A condition that holds at every clock edge outside reset.
`define SDPF_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error(msg);

// A condition that, once seen, implies another in the next cycle.
`define SDPF_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// A condition that must hold in the cycle after reset is applied.
`define SDPF_ASSERT_AFTER_RESET(lbl, cons, msg) \
    lbl: assert property (@(posedge aclk) !aresetn |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/sdpf_pkg.sv @@
// ----------------------------------------------------------------------------
// sdpf_pkg
// Widths, codes and shared types of the segment distance phase-field block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sdpf_pkg;

    // Fixed-point format of coordinates, distances and the field value.
    localparam int FRAC_BITS = 16;
    localparam int COORD_W   = 32;
    localparam int MAG_W     = 32;
    localparam int PROD_W    = 2 * MAG_W;
    localparam int SQ_W      = PROD_W + 2;
    localparam int DIST_W    = 32;
    localparam int WIDTH_W   = 31;
    localparam int FIELD_W   = 17;
    localparam int QUOT_W    = FRAC_BITS + 1;
    localparam int DEN_W     = 2 * WIDTH_W + 2;
    localparam int S_W       = DIST_W + 2;
    localparam int CFG_IDX_W = 3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_TOP_X,
        CFG_TOP_Y,
        CFG_TOP_Z,
        CFG_BOTTOM_X,
        CFG_BOTTOM_Y,
        CFG_BOTTOM_Z,
        CFG_WELL_RADIUS,
        CFG_TRANSITION_WIDTH
    } cfg_index_t;

    // Which squared distance the item ends up with.
    typedef enum logic [1:0] {
        BR_END_A,
        BR_END_B,
        BR_PERP
    } branch_t;

    // Which form the field value takes.
    typedef enum logic [1:0] {
        FV_ONE,
        FV_ZERO,
        FV_BAND
    } fv_sel_t;

    typedef struct packed {
        logic [2:0][COORD_W-1:0] top;
        logic [2:0][COORD_W-1:0] bottom;
        logic [COORD_W-1:0]      radius;
        logic [WIDTH_W-1:0]      width;
    } cfg_t;

    typedef struct packed {
        branch_t         br;
        logic [SQ_W-1:0] dot;
        logic [SQ_W-1:0] sq_e;
        logic [SQ_W-1:0] sq_a;
        logic [SQ_W-1:0] sq_b;
    } proj_t;

    typedef struct packed {
        logic [FIELD_W-1:0] field_value;
        logic [DIST_W-1:0]  segment_distance;
    } res_t;

endpackage

@@ rtl/sdpf_front.sv @@
// ----------------------------------------------------------------------------
// sdpf_front
// Differences, squares, dot product and branch choice for one point an item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdpf_front import sdpf_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [2:0][COORD_W-1:0] in_point,
    input  cfg_t                    cfg,
    output logic                    out_valid,
    output proj_t                   out_proj
);

    localparam int NS = 6;

    logic [NS-1:0] vld_reg;

    logic [2:0][COORD_W-1:0] p_reg;
    logic [2:0][MAG_W-1:0]   ma_reg, mb_reg, me_reg;
    logic [2:0][MAG_W-1:0]   ma_next, mb_next, me_next;
    logic [2:0]              neg_reg, neg_next, neg3_reg;
    logic [2:0][PROD_W-1:0]  pa_reg, pb_reg, pe_reg, pd_reg;
    logic [SQ_W-1:0]         sqa_reg, sqb_reg, sqe_reg, pos_reg, negs_reg;
    logic [SQ_W-1:0]         sqa_next, sqb_next, sqe_next, pos_next, negs_next;
    logic [SQ_W-1:0]         dot5_reg, sqa5_reg, sqb5_reg, sqe5_reg;
    logic [SQ_W:0]           diff5;
    logic                    enda5_reg;
    proj_t                   out_reg, out_next;

    // Magnitude of a 33-bit two's complement difference; it always fits 32 bits.
    function automatic logic [MAG_W-1:0] mag_of(input logic [COORD_W:0] v);
        logic [COORD_W:0] n;
        n = v[COORD_W] ? (~v + 1'b1) : v;
        return n[MAG_W-1:0];
    endfunction

    // Per-axis differences to both end points and along the segment.
    always_comb begin
        logic [COORD_W:0] da, db, de;
        for (int i = 0; i < 3; i++) begin
            da = {p_reg[i][COORD_W-1], p_reg[i]} - {cfg.top[i][COORD_W-1], cfg.top[i]};
            db = {p_reg[i][COORD_W-1], p_reg[i]}
                 - {cfg.bottom[i][COORD_W-1], cfg.bottom[i]};
            de = {cfg.bottom[i][COORD_W-1], cfg.bottom[i]}
                 - {cfg.top[i][COORD_W-1], cfg.top[i]};
            ma_next[i]  = mag_of(da);
            mb_next[i]  = mag_of(db);
            me_next[i]  = mag_of(de);
            neg_next[i] = da[COORD_W] ^ de[COORD_W];
        end
    end

    // Sums of squares, with the dot product split by sign of each term.
    always_comb begin
        sqa_next  = '0;
        sqb_next  = '0;
        sqe_next  = '0;
        pos_next  = '0;
        negs_next = '0;
        for (int i = 0; i < 3; i++) begin
            sqa_next = sqa_next + SQ_W'(pa_reg[i]);
            sqb_next = sqb_next + SQ_W'(pb_reg[i]);
            sqe_next = sqe_next + SQ_W'(pe_reg[i]);
            if (neg3_reg[i]) begin
                negs_next = negs_next + SQ_W'(pd_reg[i]);
            end else begin
                pos_next = pos_next + SQ_W'(pd_reg[i]);
            end
        end
    end

    // Signed dot product; a borrow means the projection lies before A.
    assign diff5 = {1'b0, pos_reg} - {1'b0, negs_reg};

    // Branch choice: end A, end B or the perpendicular foot.
    always_comb begin
        out_next.dot  = dot5_reg;
        out_next.sq_e = sqe5_reg;
        out_next.sq_a = sqa5_reg;
        out_next.sq_b = sqb5_reg;
        if (enda5_reg) begin
            out_next.br = BR_END_A;
        end else if (dot5_reg >= sqe5_reg) begin
            out_next.br = BR_END_B;
        end else begin
            out_next.br = BR_PERP;
        end
    end

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    // Payload stages.
    always_ff @(posedge aclk) begin
        if (en) begin
            p_reg    <= in_point;
            ma_reg   <= ma_next;
            mb_reg   <= mb_next;
            me_reg   <= me_next;
            neg_reg  <= neg_next;
            for (int i = 0; i < 3; i++) begin
                pa_reg[i] <= PROD_W'(ma_reg[i]) * PROD_W'(ma_reg[i]);
                pb_reg[i] <= PROD_W'(mb_reg[i]) * PROD_W'(mb_reg[i]);
                pe_reg[i] <= PROD_W'(me_reg[i]) * PROD_W'(me_reg[i]);
                pd_reg[i] <= PROD_W'(ma_reg[i]) * PROD_W'(me_reg[i]);
            end
            neg3_reg  <= neg_reg;
            sqa_reg   <= sqa_next;
            sqb_reg   <= sqb_next;
            sqe_reg   <= sqe_next;
            pos_reg   <= pos_next;
            negs_reg  <= negs_next;
            dot5_reg  <= diff5[SQ_W-1:0];
            sqa5_reg  <= sqa_reg;
            sqb5_reg  <= sqb_reg;
            sqe5_reg  <= sqe_reg;
            enda5_reg <= (sqe_reg == '0) || diff5[SQ_W];
            out_reg   <= out_next;
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_proj  = out_reg;

endmodule

@@ rtl/sdpf_muldiv.sv @@
// ----------------------------------------------------------------------------
// sdpf_muldiv
// Bit-serial pipeline for floor(dot * dot / |B-A|^2) and the squared distance.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdpf_muldiv import sdpf_pkg::*; (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  proj_t           in_proj,
    output logic            out_valid,
    output logic [SQ_W-1:0] out_d2
);

    localparam int N     = SQ_W;
    localparam int REM_W = SQ_W + 2;

    typedef struct packed {
        logic [1:0]      k;
        logic [SQ_W-1:0] r;
    } md_res_t;

    logic [N-1:0]    vld_reg;
    logic [SQ_W-1:0] q_reg [N];
    logic [SQ_W-1:0] r_reg [N];
    proj_t           pj_reg [N];
    logic [SQ_W-1:0] q_next [N];
    logic [SQ_W-1:0] r_next [N];
    proj_t           pj_next [N];
    logic            out_valid_reg;
    logic [SQ_W-1:0] d2_reg, d2_next;

    // One Horner step: r = 2r + bit*a, reduced by m or 2m; k counts the subtractions.
    function automatic md_res_t md_step(input logic [SQ_W-1:0] r, input logic [SQ_W-1:0] a,
                                        input logic [SQ_W-1:0] m, input logic b);
        md_res_t          res;
        logic [REM_W-1:0] t, m1, m2;
        t  = {1'b0, r, 1'b0} + (b ? {2'b00, a} : {REM_W{1'b0}});
        m1 = {2'b00, m};
        m2 = {1'b0, m, 1'b0};
        if (t >= m2) begin
            res.k = 2'd2;
            t     = t - m2;
        end else if (t >= m1) begin
            res.k = 2'd1;
            t     = t - m1;
        end else begin
            res.k = 2'd0;
        end
        res.r = t[SQ_W-1:0];
        return res;
    endfunction

    // Each stage consumes one bit of the dot product, most significant first.
    always_comb begin
        logic [SQ_W-1:0] src_q, src_r;
        proj_t           src_p;
        md_res_t         st;
        for (int k = 0; k < N; k++) begin
            if (k == 0) begin
                src_q = '0;
                src_r = '0;
                src_p = in_proj;
            end else begin
                src_q = q_reg[k-1];
                src_r = r_reg[k-1];
                src_p = pj_reg[k-1];
            end
            st         = md_step(src_r, src_p.dot, src_p.sq_e, src_p.dot[N-1-k]);
            r_next[k]  = st.r;
            q_next[k]  = {src_q[SQ_W-2:0], 1'b0} + SQ_W'(st.k);
            pj_next[k] = src_p;
        end
    end

    // Squared distance for the chosen branch; rounding can never push it below zero.
    always_comb begin
        case (pj_reg[N-1].br)
            BR_END_A: d2_next = pj_reg[N-1].sq_a;
            BR_END_B: d2_next = pj_reg[N-1].sq_b;
            BR_PERP: begin
                if (q_reg[N-1] > pj_reg[N-1].sq_a) begin
                    d2_next = '0;
                end else begin
                    d2_next = pj_reg[N-1].sq_a - q_reg[N-1];
                end
            end
            default: d2_next = pj_reg[N-1].sq_a;
        endcase
    end

    // Valid bits travel with the data.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg       <= {vld_reg[N-2:0], in_valid};
            out_valid_reg <= vld_reg[N-1];
        end
    end

    // Payload stages.
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < N; k++) begin
                q_reg[k]  <= q_next[k];
                r_reg[k]  <= r_next[k];
                pj_reg[k] <= pj_next[k];
            end
            d2_reg <= d2_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_d2    = d2_reg;

endmodule

@@ rtl/sdpf_sqrt.sv @@
// ----------------------------------------------------------------------------
// sdpf_sqrt
// Pipelined integer square root, one result bit a stage, saturating at 32 bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdpf_sqrt import sdpf_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [SQ_W-1:0]   in_d2,
    output logic              out_valid,
    output logic [DIST_W-1:0] out_dist
);

    localparam int N    = DIST_W;
    localparam int RAD_W = 2 * DIST_W;

    logic [N-1:0]       vld_reg;
    logic [RAD_W-1:0]   rem_reg [N];
    logic [DIST_W-1:0]  res_reg [N];
    logic               sat_reg [N];
    logic [RAD_W-1:0]   rem_next [N];
    logic [DIST_W-1:0]  res_next [N];
    logic               sat_next [N];

    // Stage k decides root bit N-1-k against the remainder x - root^2.
    always_comb begin
        logic [RAD_W-1:0]  src_rem, t;
        logic [DIST_W-1:0] src_res;
        logic              src_sat;
        for (int k = 0; k < N; k++) begin
            if (k == 0) begin
                src_rem = in_d2[RAD_W-1:0];
                src_res = '0;
                src_sat = |in_d2[SQ_W-1:RAD_W];
            end else begin
                src_rem = rem_reg[k-1];
                src_res = res_reg[k-1];
                src_sat = sat_reg[k-1];
            end
            t = (RAD_W'(src_res) << (N - k)) + (RAD_W'(1) << (2 * (N - 1 - k)));
            if (src_rem >= t) begin
                rem_next[k] = src_rem - t;
                res_next[k] = src_res | (DIST_W'(1) << (N - 1 - k));
            end else begin
                rem_next[k] = src_rem;
                res_next[k] = src_res;
            end
            sat_next[k] = src_sat;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[N-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int k = 0; k < N; k++) begin
                rem_reg[k] <= rem_next[k];
                res_reg[k] <= res_next[k];
                sat_reg[k] <= sat_next[k];
            end
        end
    end

    // A squared distance of 2^64 or more reports the largest distance.
    assign out_valid = vld_reg[N-1];
    assign out_dist  = sat_reg[N-1] ? {DIST_W{1'b1}} : res_reg[N-1];

endmodule

@@ rtl/sdpf_band.sv @@
// ----------------------------------------------------------------------------
// sdpf_band
// Phase-field profile from the distance: case split, product and fraction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sdpf_band import sdpf_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DIST_W-1:0] in_dist,
    input  cfg_t              cfg,
    output logic              out_valid,
    output res_t              out_res
);

    localparam int N  = FRAC_BITS;
    localparam int NS = N + 3;

    logic [NS-1:0]       vld_reg;
    logic [S_W-1:0]      s_full;
    logic                rad_le0, s_le0, s_lt2e;
    fv_sel_t             sel1_reg, sel1_next, sel2_reg;
    logic [DIST_W-1:0]   s1_reg, dist1_reg, dist2_reg;
    logic [WIDTH_W+1:0]  rest;
    logic [DEN_W-1:0]    num2_reg, den2_reg;
    logic [DEN_W-1:0]    r_reg [N];
    logic [FRAC_BITS-1:0] q_reg [N];
    logic [DEN_W-1:0]    den_reg [N];
    fv_sel_t             sel_reg [N];
    logic [DIST_W-1:0]   dist_reg [N];
    logic [DEN_W-1:0]    r_next [N];
    logic [FRAC_BITS-1:0] q_next [N];
    logic [QUOT_W-1:0]   value;
    res_t                out_reg;

    // Distance beyond the radius, and which piece of the profile applies.
    assign s_full  = {2'b00, in_dist} - {{2{cfg.radius[COORD_W-1]}}, cfg.radius};
    assign rad_le0 = cfg.radius[COORD_W-1] || (cfg.radius == '0);
    assign s_le0   = s_full[S_W-1] || (s_full == '0);
    assign s_lt2e  = s_full < S_W'({cfg.width, 1'b0});

    always_comb begin
        if (rad_le0) begin
            sel1_next = FV_ONE;
        end else if (s_le0) begin
            sel1_next = FV_ZERO;
        end else if (s_lt2e) begin
            sel1_next = FV_BAND;
        end else begin
            sel1_next = FV_ONE;
        end
    end

    // Band numerator 4e - s is positive whenever the band piece is chosen.
    assign rest = {cfg.width, 2'b00} - (WIDTH_W + 2)'(s1_reg);

    // Restoring division of s*(4e-s) * 2^FRAC_BITS by 4e^2, one bit a stage.
    always_comb begin
        logic [DEN_W-1:0]     src_r, src_den;
        logic [FRAC_BITS-1:0] src_q;
        logic [DEN_W:0]       t;
        for (int k = 0; k < N; k++) begin
            if (k == 0) begin
                src_r   = num2_reg;
                src_q   = '0;
                src_den = den2_reg;
            end else begin
                src_r   = r_reg[k-1];
                src_q   = q_reg[k-1];
                src_den = den_reg[k-1];
            end
            t = {src_r, 1'b0};
            if (t >= {1'b0, src_den}) begin
                t         = t - {1'b0, src_den};
                q_next[k] = {src_q[FRAC_BITS-2:0], 1'b1};
            end else begin
                q_next[k] = {src_q[FRAC_BITS-2:0], 1'b0};
            end
            r_next[k] = t[DEN_W-1:0];
        end
    end

    // Final value: zero, one, or the band fraction.
    always_comb begin
        case (sel_reg[N-1])
            FV_ZERO: value = '0;
            FV_BAND: value = {1'b0, q_reg[N-1]};
            FV_ONE:  value = {1'b1, {FRAC_BITS{1'b0}}};
            default: value = {1'b1, {FRAC_BITS{1'b0}}};
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NS-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sel1_reg  <= sel1_next;
            s1_reg    <= s_full[DIST_W-1:0];
            dist1_reg <= in_dist;
            num2_reg  <= DEN_W'(s1_reg) * DEN_W'(rest);
            den2_reg  <= {(DEN_W - 2)'(cfg.width) * (DEN_W - 2)'(cfg.width), 2'b00};
            sel2_reg  <= sel1_reg;
            dist2_reg <= dist1_reg;
            for (int k = 0; k < N; k++) begin
                r_reg[k] <= r_next[k];
                q_reg[k] <= q_next[k];
                if (k == 0) begin
                    den_reg[k]  <= den2_reg;
                    sel_reg[k]  <= sel2_reg;
                    dist_reg[k] <= dist2_reg;
                end else begin
                    den_reg[k]  <= den_reg[k-1];
                    sel_reg[k]  <= sel_reg[k-1];
                    dist_reg[k] <= dist_reg[k-1];
                end
            end
            out_reg.field_value      <= FIELD_W'(value);
            out_reg.segment_distance <= dist_reg[N-1];
        end
    end

    assign out_valid = vld_reg[NS-1];
    assign out_res   = out_reg;

endmodule

@@ rtl/segment_distance_phase_field.sv @@
// ----------------------------------------------------------------------------
// segment_distance_phase_field
// Distance from a point to a 3-D segment and the phase-field value it gives.
// ----------------------------------------------------------------------------
// The block takes one grid point per clock unless stalled and returns, for
// each, the floored Euclidean distance to the configured segment and a Q1.16
// phase-field value, in order. Throughput is one item per cycle unless
// stalled. An item passes the vector arithmetic, bit-serial projection
// quotient, square root, profile and output register. The long bit-serial
// quotient and root pipelines set the latency. A two-entry output buffer
// lets the pipeline keep accepting while one result waits; input ready drops
// only when both entries are full. Configuration must be written through the
// cfg port while no item is in flight; the block does not enforce this.
`timescale 1ns / 1ps

module segment_distance_phase_field import sdpf_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [COORD_W-1:0]   s_point_x,
    input  logic [COORD_W-1:0]   s_point_y,
    input  logic [COORD_W-1:0]   s_point_z,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [FIELD_W-1:0]   m_field_value,
    output logic [DIST_W-1:0]    m_segment_distance,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COORD_W-1:0]   cfg_data
);

    cfg_t                    cfg_reg;
    logic                    en;
    logic [2:0][COORD_W-1:0] point;
    logic                    fr_valid, md_valid, sq_valid, bd_valid;
    proj_t                   fr_proj;
    logic [SQ_W-1:0]         md_d2;
    logic [DIST_W-1:0]       sq_dist;
    res_t                    bd_res;
    logic                    out_valid_reg, skid_valid_reg;
    res_t                    out_reg, skid_reg;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.top    <= '0;
            cfg_reg.bottom <= '0;
            cfg_reg.radius <= '0;
            cfg_reg.width  <= WIDTH_W'(1) << FRAC_BITS;
        end else if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_TOP_X:            cfg_reg.top[0]    <= cfg_data;
                CFG_TOP_Y:            cfg_reg.top[1]    <= cfg_data;
                CFG_TOP_Z:            cfg_reg.top[2]    <= cfg_data;
                CFG_BOTTOM_X:         cfg_reg.bottom[0] <= cfg_data;
                CFG_BOTTOM_Y:         cfg_reg.bottom[1] <= cfg_data;
                CFG_BOTTOM_Z:         cfg_reg.bottom[2] <= cfg_data;
                CFG_WELL_RADIUS:      cfg_reg.radius    <= cfg_data;
                CFG_TRANSITION_WIDTH: cfg_reg.width     <= cfg_data[WIDTH_W-1:0];
                default: ;
            endcase
        end
    end

    // The whole pipeline advances unless the skid entry holds an item.
    assign en      = !skid_valid_reg;
    assign s_ready = en;
    assign point   = {s_point_z, s_point_y, s_point_x};

    sdpf_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .in_point  (point),
        .cfg       (cfg_reg),
        .out_valid (fr_valid),
        .out_proj  (fr_proj)
    );

    sdpf_muldiv u_muldiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (fr_valid),
        .in_proj   (fr_proj),
        .out_valid (md_valid),
        .out_d2    (md_d2)
    );

    sdpf_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (md_valid),
        .in_d2     (md_d2),
        .out_valid (sq_valid),
        .out_dist  (sq_dist)
    );

    sdpf_band u_band (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_dist   (sq_dist),
        .cfg       (cfg_reg),
        .out_valid (bd_valid),
        .out_res   (bd_res)
    );

    // Output register with a skid entry behind it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (skid_valid_reg) begin
            if (m_ready) begin
                skid_valid_reg <= 1'b0;
            end
        end else if (bd_valid) begin
            if (!out_valid_reg || m_ready) begin
                out_valid_reg <= 1'b1;
            end else begin
                skid_valid_reg <= 1'b1;
            end
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (skid_valid_reg) begin
            if (m_ready) begin
                out_reg <= skid_reg;
            end
        end else if (bd_valid) begin
            if (!out_valid_reg || m_ready) begin
                out_reg <= bd_res;
            end else begin
                skid_reg <= bd_res;
            end
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_field_value      = out_reg.field_value;
    assign m_segment_distance = out_reg.segment_distance;

endmodule

@@ rtl/sdpf_checker.sv @@
// ----------------------------------------------------------------------------
// sdpf_checker
// Port-level checks of the result channel and back-pressure behaviour.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "segment_distance_phase_field_assert.svh"

module sdpf_checker import sdpf_pkg::*; (
    input logic               aclk,
    input logic               aresetn,
    input logic               s_ready,
    input logic               m_valid,
    input logic               m_ready,
    input logic [FIELD_W-1:0] m_field_value,
    input logic [DIST_W-1:0]  m_segment_distance
);

    // A held result stays offered.
    `SDPF_ASSERT_NEXT(a_m_hold, m_valid && !m_ready, m_valid, "result dropped while stalled")

    // A held result keeps its payload.
    `SDPF_ASSERT_NEXT(a_m_stable, m_valid && !m_ready,
        $stable(m_field_value) && $stable(m_segment_distance), "result changed while stalled")

    // Input back-pressure only comes from a result waiting at the output.
    `SDPF_ASSERT_ALWAYS(a_ready_cause, s_ready || m_valid, "input stalled with no result waiting")

    // Reset empties the output.
    `SDPF_ASSERT_AFTER_RESET(a_reset_empty, !m_valid, "result offered after reset")

endmodule

bind segment_distance_phase_field sdpf_checker u_sdpf_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .s_ready            (s_ready),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_field_value      (m_field_value),
    .m_segment_distance (m_segment_distance)
);

@@ tb/sv/segment_distance_phase_field_tb.sv @@
// ----------------------------------------------------------------------------
// Segment distance phase-field testbench
// Drives grid points through the block under several segment, radius and
// band-width settings. Each result is checked against a local predictor that
// works the point-to-segment distance and the field value out exactly.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module segment_distance_phase_field_tb;
    import sdpf_pkg::*;

    localparam int CLK_PERIOD  = 12;
    localparam int DRAIN_WAIT  = 140;
    localparam int CYCLE_LIMIT = 300000;
    localparam logic [FIELD_W-1:0] FIELD_ONE = 17'h10000;

    typedef struct {
        logic [FIELD_W-1:0] field_value;
        logic [DIST_W-1:0]  distance;
    } field_result_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [COORD_W-1:0]   s_point_x;
    logic [COORD_W-1:0]   s_point_y;
    logic [COORD_W-1:0]   s_point_z;
    logic                 m_valid;
    logic                 m_ready;
    logic [FIELD_W-1:0]   m_field_value;
    logic [DIST_W-1:0]    m_segment_distance;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_W-1:0]   cfg_data;

    // Local copy of the segment and profile settings.
    logic [COORD_W-1:0] end_a [3];
    logic [COORD_W-1:0] end_b [3];
    logic [COORD_W-1:0] radius_mirror;
    logic [WIDTH_W-1:0] band_mirror;

    field_result_t expected_fields[$];
    int  mismatches;
    int  points_sent;
    int  results_seen;
    int  cycle_count;
    int  ready_hold;
    int  ready_gap;
    bit  quiet;

    segment_distance_phase_field u_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_point_x          (s_point_x),
        .s_point_y          (s_point_y),
        .s_point_z          (s_point_z),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_field_value      (m_field_value),
        .m_segment_distance (m_segment_distance),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #(CLK_PERIOD / 2) aclk = ~aclk;
    end

    // Magnitude of a 35-bit signed difference, widened for exact products.
    function automatic logic [139:0] magnitude(input logic signed [34:0] v);
        logic [34:0] m;
        m = v[34] ? -v : v;
        return 140'(m);
    endfunction

    // Distance from the point to segment A-B, then the phase-field value.
    function automatic field_result_t segment_field(input logic [COORD_W-1:0] pt [3]);
        logic signed [34:0] da, db, de;
        logic [139:0] ma, mb, me, sq_a, sq_b, sq_e, dot_pos, dot_neg, dot, quot, d2;
        logic [139:0] cand, num, den, e4;
        logic [31:0]  root;
        logic signed [35:0] s;
        field_result_t r;
        sq_a = 0; sq_b = 0; sq_e = 0; dot_pos = 0; dot_neg = 0;
        for (int i = 0; i < 3; i++) begin
            da = {{3{pt[i][31]}}, pt[i]} - {{3{end_a[i][31]}}, end_a[i]};
            db = {{3{pt[i][31]}}, pt[i]} - {{3{end_b[i][31]}}, end_b[i]};
            de = {{3{end_b[i][31]}}, end_b[i]} - {{3{end_a[i][31]}}, end_a[i]};
            ma = magnitude(da);
            mb = magnitude(db);
            me = magnitude(de);
            sq_a += ma * ma;
            sq_b += mb * mb;
            sq_e += me * me;
            if (da[34] != de[34]) dot_neg += ma * me;
            else dot_pos += ma * me;
        end
        // Nearer end point or the perpendicular foot.
        if (sq_e == 0 || dot_neg > dot_pos) begin
            d2 = sq_a;
        end else begin
            dot = dot_pos - dot_neg;
            if (dot >= sq_e) begin
                d2 = sq_b;
            end else begin
                quot = (dot * dot) / sq_e;
                d2 = (quot > sq_a) ? 140'd0 : sq_a - quot;
            end
        end
        // Floored root, saturated when the square does not fit 64 bits.
        if (d2 >= (140'd1 << 64)) begin
            root = 32'hFFFF_FFFF;
        end else begin
            root = 0;
            for (int b = 31; b >= 0; b--) begin
                cand = 140'(root | (32'd1 << b));
                if (cand * cand <= d2) root = cand[31:0];
            end
        end
        r.distance = root;
        // Profile across the transition band.
        if (radius_mirror[31] || radius_mirror == 0) begin
            r.field_value = FIELD_ONE;
        end else begin
            s = $signed({4'b0, root}) - $signed({{4{radius_mirror[31]}}, radius_mirror});
            if (s <= 0) begin
                r.field_value = '0;
            end else if (140'(s) < 2 * 140'(band_mirror)) begin
                e4 = 4 * 140'(band_mirror);
                num = 140'(s) * (e4 - 140'(s));
                den = e4 * 140'(band_mirror);
                r.field_value = FIELD_W'((num << FRAC_BITS) / den);
            end else begin
                r.field_value = FIELD_ONE;
            end
        end
        return r;
    endfunction

    // Writes one register and updates the local copy on acceptance.
    task automatic write_reg(input cfg_index_t idx, input logic [COORD_W-1:0] data);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            CFG_TOP_X, CFG_TOP_Y, CFG_TOP_Z: begin
                end_a[int'(idx) - int'(CFG_TOP_X)] = data;
            end
            CFG_BOTTOM_X, CFG_BOTTOM_Y, CFG_BOTTOM_Z: begin
                end_b[int'(idx) - int'(CFG_BOTTOM_X)] = data;
            end
            CFG_WELL_RADIUS: begin
                radius_mirror = data;
            end
            default: begin
                band_mirror = data[WIDTH_W-1:0];
            end
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_segment(input logic [31:0] ax, ay, az, bx, by, bz);
        write_reg(CFG_TOP_X, ax);
        write_reg(CFG_TOP_Y, ay);
        write_reg(CFG_TOP_Z, az);
        write_reg(CFG_BOTTOM_X, bx);
        write_reg(CFG_BOTTOM_Y, by);
        write_reg(CFG_BOTTOM_Z, bz);
    endtask

    task automatic set_profile(input logic [31:0] radius, input logic [31:0] band);
        write_reg(CFG_WELL_RADIUS, radius);
        write_reg(CFG_TRANSITION_WIDTH, band);
    endtask

    // Offers one point; valid stays high until the item is taken.
    task automatic send_point(input logic [31:0] px, py, pz);
        logic [COORD_W-1:0] pt [3];
        @(negedge aclk);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            s_valid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge aclk);
        end
        s_valid   = 1'b1;
        s_point_x = px;
        s_point_y = py;
        s_point_z = pz;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pt[0] = px; pt[1] = py; pt[2] = pz;
        expected_fields.push_back(segment_field(pt));
        points_sent++;
    endtask

    task automatic drain();
        @(negedge aclk);
        s_valid = 1'b0;
        while (expected_fields.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // A point near one end point, near the other, near the midpoint, or anywhere.
    task automatic send_random_point();
        logic [31:0] off [3];
        int pick;
        pick = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++) begin
            off[i] = $urandom_range(0, 1) ? 32'($signed($urandom_range(0, 20'hFFFFF)) - 32'sh80000)
                                          : 32'($signed($urandom_range(0, 16'hFFFF)) - 32'sh8000);
        end
        if (pick < 3)
            send_point(end_a[0] + off[0], end_a[1] + off[1], end_a[2] + off[2]);
        else if (pick < 6)
            send_point(end_b[0] + off[0], end_b[1] + off[1], end_b[2] + off[2]);
        else if (pick < 8)
            send_point(end_a[0] + (end_b[0] - end_a[0]) / 2 + off[0],
                       end_a[1] + (end_b[1] - end_a[1]) / 2 + off[1],
                       end_a[2] + (end_b[2] - end_a[2]) / 2 + off[2]);
        else
            send_point($urandom, $urandom, $urandom);
    endtask

    function automatic logic [31:0] random_coord();
        return $urandom_range(0, 2) == 0 ? $urandom
                                         : 32'($signed($urandom_range(0, 24'hFFFFFF)) - 32'sh800000);
    endfunction

    // Default settings: a point-sized segment at the origin, radius zero.
    task automatic test_reset_defaults();
        send_point(32'h0, 32'h0, 32'h0);
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h0001_0000, 32'hFFFF_FFFF, 32'h8000_0000);
        drain();
    endtask

    // Each branch of the projection and each form of the profile.
    task automatic test_segment_branches();
        set_segment(32'h0, 32'h0, 32'h0, 32'h000A_0000, 32'h0, 32'h0);
        set_profile(32'h0001_0000, 32'h0000_8000);
        send_point(32'hFFFD_0000, 32'h0, 32'h0);          // behind the first end
        send_point(32'h000F_0000, 32'h0, 32'h0);          // past the second end
        send_point(32'h000A_0000, 32'h0002_0000, 32'h0);  // projection exactly at one
        send_point(32'h0005_0000, 32'h0000_8000, 32'h0);  // inside the radius
        send_point(32'h0005_0000, 32'h0001_0000, 32'h0);  // on the radius
        send_point(32'h0005_0000, 32'h0001_4000, 32'h0);  // inside the band
        send_point(32'h0005_0000, 32'h0001_C000, 32'h0);  // near the band edge
        send_point(32'h0005_0000, 32'h0003_0000, 32'h0004_0000);
        drain();
        set_profile(32'hFFFF_0000, 32'h0000_0001);        // negative radius
        send_point(32'h0003_0000, 32'h0, 32'h0);
        send_point(32'h0003_0000, 32'h0007_0000, 32'h0);
        drain();
    endtask

    // Degenerate segment and distances too large to represent.
    task automatic test_degenerate_and_saturation();
        set_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        set_profile(32'h7FFF_FFFF, 32'hFFFF_FFFF);        // top bit of width dropped
        send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_point(32'h0, 32'h0, 32'h0);
        drain();
        set_segment(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                    32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        set_profile(32'h0000_0001, 32'h0000_0001);
        send_point(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
        send_point(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        send_point(32'h1234_5678, 32'hEDCB_A987, 32'h0);
        drain();
    endtask

    // Several random settings, each followed by a batch of points.
    task automatic test_random_settings();
        logic [31:0] radius, band;
        for (int k = 0; k < 8; k++) begin
            set_segment(random_coord(), random_coord(), random_coord(),
                        random_coord(), random_coord(), random_coord());
            case ($urandom_range(0, 3))
                0: radius = 32'($signed($urandom_range(0, 16'hFFFF)) * -1);
                1: radius = $urandom_range(1, 24'h7FFFFF);
                2: radius = $urandom;
                default: radius = $urandom_range(1, 20'hFFFFF);
            endcase
            band = $urandom_range(0, 1) ? $urandom_range(1, 24'hFFFFFF) : $urandom;
            set_profile(radius, band);
            repeat (150) send_random_point();
            drain();
        end
    endtask

    // Receiver stops for a long while so that the block fills and stalls.
    task automatic test_backpressure();
        set_segment(32'h0, 32'h0, 32'h0, 32'h0010_0000, 32'h0008_0000, 32'hFFF0_0000);
        set_profile(32'h0002_0000, 32'h0001_0000);
        ready_hold = 400;
        repeat (200) send_random_point();
        drain();
    endtask

    // Closing stretch with no idling on either side.
    task automatic test_steady_stream();
        quiet = 1'b1;
        set_segment(32'h0, 32'h0, 32'h0, 32'h7FFF_FFFF, 32'h0, 32'h0);
        set_profile(32'h0000_8000, 32'h7FFF_FFFF);
        repeat (150) send_random_point();
        drain();
    endtask

    // Result side: random bursts of backpressure plus the long hold.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready = 1'b0;
        end else if (ready_hold > 0) begin
            ready_hold--;
            m_ready = 1'b0;
        end else if (quiet) begin
            m_ready = 1'b1;
        end else if (ready_gap > 0) begin
            ready_gap--;
            m_ready = 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            ready_gap = $urandom_range(0, 3);
            m_ready = 1'b0;
        end else begin
            m_ready = 1'b1;
        end
    end

    // Compares each result with the oldest expectation; also the run limit.
    always @(posedge aclk) begin
        field_result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: run limit reached", $time);
            $display("FAILURE");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (expected_fields.size() == 0) begin
                $display("%0t: unexpected item, field %h distance %h", $time,
                         m_field_value, m_segment_distance);
                mismatches++;
            end else begin
                want = expected_fields.pop_front();
                if (m_field_value !== want.field_value) begin
                    $display("%0t: field_value expected %h actual %h", $time,
                             want.field_value, m_field_value);
                    mismatches++;
                end
                if (m_segment_distance !== want.distance) begin
                    $display("%0t: segment_distance expected %h actual %h", $time,
                             want.distance, m_segment_distance);
                    mismatches++;
                end
            end
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_point_x = '0; s_point_y = '0; s_point_z = '0;
        cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
        m_ready = 1'b0;
        mismatches = 0; points_sent = 0; results_seen = 0; cycle_count = 0;
        ready_hold = 0; ready_gap = 0; quiet = 1'b0;
        for (int i = 0; i < 3; i++) begin
            end_a[i] = '0;
            end_b[i] = '0;
        end
        radius_mirror = '0;
        band_mirror = 31'h10000;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_segment_branches();
        test_degenerate_and_saturation();
        test_random_settings();
        test_backpressure();
        test_steady_stream();

        if (expected_fields.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, expected_fields.size());
            mismatches++;
        end
        $display("Covered %0d points and %0d results over end-point, perpendicular,", points_sent,
                 results_seen);
        $display("degenerate, saturated, radius and band cases, with a long output stall.");
        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
+incdir+rtl
rtl/sdpf_pkg.sv
rtl/sdpf_front.sv
rtl/sdpf_muldiv.sv
rtl/sdpf_sqrt.sv
rtl/sdpf_band.sv
rtl/segment_distance_phase_field.sv
rtl/sdpf_checker.sv
tb/sv/segment_distance_phase_field_tb.sv
